// ===== hw/rtl/rtds_pkg.sv =====
// Package with the types, constants and helpers of the RFID tag whitelist door sequencer.
package rtds_pkg;

	localparam int KEY_W           = 40;
	localparam int TIME_W          = 16;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = KEY_W;
	localparam int NUM_KEYS        = 4;
	localparam int KEY_IDX_W       = 2;
	localparam int CODE_DIGITS_DEF = 10;

	localparam logic [7:0] BYTE_LF = 8'd10;
	localparam logic [7:0] BYTE_CR = 8'd13;

	localparam logic [KEY_W-1:0] KEY_ZERO_RST  = 40'h2200536C73;
	localparam logic [KEY_W-1:0] KEY_ONE_RST   = 40'h2100DFC897;
	localparam logic [KEY_W-1:0] KEY_TWO_RST   = 40'h2200776E9C;
	localparam logic [KEY_W-1:0] KEY_THREE_RST = 40'h36005B7320;

	localparam logic [TIME_W-1:0] DRIVE_TIME_RST    = 16'd1000;
	localparam logic [TIME_W-1:0] SETTLE_TIME_RST   = 16'd3000;
	localparam logic [TIME_W-1:0] DEBOUNCE_TIME_RST = 16'd100;
	localparam logic [TIME_W-1:0] PRELOCK_TIME_RST  = 16'd500;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_COLLECT,
		PH_UNLOCK,
		PH_SETTLE,
		PH_WATCH,
		PH_DEBOUNCE,
		PH_PRELOCK,
		PH_LOCK
	} phase_t;

	typedef enum logic [1:0] {
		SERVO_OFF    = 2'd0,
		SERVO_UNLOCK = 2'd1,
		SERVO_LOCK   = 2'd2
	} servo_t;

	typedef enum logic [0:0] {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_ZERO,
		REG_KEY_ONE,
		REG_KEY_TWO,
		REG_KEY_THREE,
		REG_DRIVE_TIME,
		REG_SETTLE_TIME,
		REG_DEBOUNCE_TIME,
		REG_PRELOCK_TIME
	} cfg_reg_t;

	typedef struct packed {
		logic [NUM_KEYS-1:0][KEY_W-1:0] key;
		logic [TIME_W-1:0]              drive_time;
		logic [TIME_W-1:0]              settle_time;
		logic [TIME_W-1:0]              debounce_time;
		logic [TIME_W-1:0]              prelock_time;
	} cfg_t;

	// Returns a valid flag above the nibble value of an uppercase hex digit.
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, 4'(b - 8'h30)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r = {1'b1, 4'(b - 8'h37)};
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/rtds_item_if.sv =====
// Input channel interface carrying serial bytes and millisecond ticks.
interface rtds_item_if
	import rtds_pkg::*;
;
	logic       valid;
	logic       ready;
	logic [0:0] opcode;
	logic [7:0] rx_byte;
	logic       door_pin;

	modport source (output valid, output opcode, output rx_byte, output door_pin, input ready);
	modport sink (input valid, input opcode, input rx_byte, input door_pin, output ready);
endinterface

// ===== hw/rtl/rtds_result_if.sv =====
// Result channel interface carrying servo command and frame status.
interface rtds_result_if
	import rtds_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [1:0]           servo_drive;
	logic                 door_busy;
	logic                 tag_accepted;
	logic [KEY_IDX_W-1:0] matched_key;
	logic                 frame_rejected;

	modport source (output valid, output servo_drive, output door_busy, output tag_accepted,
		output matched_key, output frame_rejected, input ready);
	modport sink (input valid, input servo_drive, input door_busy, input tag_accepted,
		input matched_key, input frame_rejected, output ready);
endinterface

// ===== hw/rtl/rtds_cfg_if.sv =====
// Configuration write channel interface.
interface rtds_cfg_if
	import rtds_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/rtds_regs.sv =====
// Configuration register file holding the four keys and the four step durations.
module rtds_regs
	import rtds_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	rtds_cfg_if.sink   cfg,
	output cfg_t       cfg_q
);

	logic wr_en;

	assign cfg.ready = 1'b1;
	assign wr_en     = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key[0]         <= KEY_ZERO_RST;
			cfg_q.key[1]         <= KEY_ONE_RST;
			cfg_q.key[2]         <= KEY_TWO_RST;
			cfg_q.key[3]         <= KEY_THREE_RST;
			cfg_q.drive_time     <= DRIVE_TIME_RST;
			cfg_q.settle_time    <= SETTLE_TIME_RST;
			cfg_q.debounce_time  <= DEBOUNCE_TIME_RST;
			cfg_q.prelock_time   <= PRELOCK_TIME_RST;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_KEY_ZERO:      cfg_q.key[0]        <= cfg.data;
				REG_KEY_ONE:       cfg_q.key[1]        <= cfg.data;
				REG_KEY_TWO:       cfg_q.key[2]        <= cfg.data;
				REG_KEY_THREE:     cfg_q.key[3]        <= cfg.data;
				REG_DRIVE_TIME:    cfg_q.drive_time    <= cfg.data[TIME_W-1:0];
				REG_SETTLE_TIME:   cfg_q.settle_time   <= cfg.data[TIME_W-1:0];
				REG_DEBOUNCE_TIME: cfg_q.debounce_time <= cfg.data[TIME_W-1:0];
				REG_PRELOCK_TIME:  cfg_q.prelock_time  <= cfg.data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/rfid_tag_whitelist_door_sequencer_top.sv =====
// Top level of the RFID tag whitelist door sequencer: frame parser, key match and door timing.
// Every beat on the item channel produces exactly one beat on the result channel. The block
// takes a new item in every cycle unless stalled: the parser and door state are updated in the
// same cycle the item is accepted, and the result lands in a single output register, so
// throughput is one item per clock while the sink keeps up. The item channel stalls only while
// that output register holds a result the sink has not yet taken. Configuration writes are
// taken at any time; they should be issued only while no frame or door sequence is running.
module rfid_tag_whitelist_door_sequencer_top
	import rtds_pkg::*;
#(
	parameter int CODE_DIGITS = CODE_DIGITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	rtds_item_if.sink       item,
	rtds_result_if.source   result,
	rtds_cfg_if.sink        cfg
);

	localparam int CODE_W = 4 * CODE_DIGITS;
	localparam int CNT_W  = $clog2(CODE_DIGITS + 1);
	localparam int CMP_W  = (CODE_W > KEY_W) ? CODE_W : KEY_W;

	cfg_t cfg_q;

	phase_t              phase_q, phase_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d, cnt_inc;
	logic [CODE_W-1:0]   code_q, code_d, code_shifted;
	logic                nonhex_q, nonhex_d;
	logic [TIME_W-1:0]   timer_q, timer_d, timer_inc;

	logic [4:0]          hex;
	logic [NUM_KEYS-1:0] hit;
	logic                last_digit;
	logic                accept;

	logic                 acc_d, rej_d;
	logic [KEY_IDX_W-1:0] which_d;
	servo_t               servo_d;
	logic                 busy_d;

	logic                 res_vld_q;
	servo_t               servo_s1;
	logic                 busy_s1;
	logic                 acc_s1;
	logic [KEY_IDX_W-1:0] which_s1;
	logic                 rej_s1;

	rtds_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_q  (cfg_q)
	);

	assign item.ready = !res_vld_q || result.ready;
	assign accept     = item.valid && item.ready;

	assign hex          = hex_digit(item.rx_byte);
	assign code_shifted = CODE_W'({code_q, hex[3:0]});
	assign cnt_inc      = cnt_q + 1'b1;
	assign last_digit   = (cnt_inc == CNT_W'(CODE_DIGITS));
	assign timer_inc    = timer_q + 1'b1;

	always_comb begin
		for (int i = 0; i < NUM_KEYS; i++) begin
			hit[i] = (CMP_W'(code_shifted) == CMP_W'(cfg_q.key[i]));
		end
	end

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		code_d   = code_q;
		nonhex_d = nonhex_q;
		timer_d  = timer_q;
		acc_d    = 1'b0;
		rej_d    = 1'b0;
		which_d  = '0;
		if (opcode_t'(item.opcode) == OP_BYTE) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (item.rx_byte == BYTE_LF) begin
						phase_d  = PH_COLLECT;
						cnt_d    = '0;
						code_d   = '0;
						nonhex_d = 1'b0;
					end
				end
				PH_COLLECT: begin
					if (item.rx_byte == BYTE_LF || item.rx_byte == BYTE_CR) begin
						rej_d   = 1'b1;
						phase_d = PH_IDLE;
						timer_d = '0;
					end else begin
						code_d   = code_shifted;
						nonhex_d = nonhex_q || !hex[4];
						cnt_d    = cnt_inc;
						if (last_digit) begin
							cnt_d   = '0;
							timer_d = '0;
							if (!nonhex_d && (|hit)) begin
								acc_d   = 1'b1;
								phase_d = PH_UNLOCK;
								if (hit[0]) begin
									which_d = KEY_IDX_W'(0);
								end else if (hit[1]) begin
									which_d = KEY_IDX_W'(1);
								end else if (hit[2]) begin
									which_d = KEY_IDX_W'(2);
								end else begin
									which_d = KEY_IDX_W'(3);
								end
							end else begin
								rej_d   = 1'b1;
								phase_d = PH_IDLE;
							end
						end
					end
				end
				default: ;
			endcase
		end else begin
			unique case (phase_q)
				PH_UNLOCK: begin
					timer_d = timer_inc;
					if (timer_inc >= cfg_q.drive_time) begin
						phase_d = PH_SETTLE;
						timer_d = '0;
					end
				end
				PH_SETTLE: begin
					timer_d = timer_inc;
					if (timer_inc >= cfg_q.settle_time) begin
						phase_d = PH_WATCH;
						timer_d = '0;
					end
				end
				PH_WATCH: begin
					if (!item.door_pin) begin
						phase_d = PH_DEBOUNCE;
						timer_d = '0;
					end
				end
				PH_DEBOUNCE: begin
					timer_d = timer_inc;
					if (timer_inc >= cfg_q.debounce_time) begin
						phase_d = item.door_pin ? PH_WATCH : PH_PRELOCK;
						timer_d = '0;
					end
				end
				PH_PRELOCK: begin
					timer_d = timer_inc;
					if (timer_inc >= cfg_q.prelock_time) begin
						phase_d = PH_LOCK;
						timer_d = '0;
					end
				end
				PH_LOCK: begin
					timer_d = timer_inc;
					if (timer_inc >= cfg_q.drive_time) begin
						phase_d = PH_IDLE;
						timer_d = '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (phase_d)
			PH_UNLOCK: servo_d = SERVO_UNLOCK;
			PH_LOCK:   servo_d = SERVO_LOCK;
			default:   servo_d = SERVO_OFF;
		endcase
		busy_d = (phase_d != PH_IDLE) && (phase_d != PH_COLLECT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cnt_q    <= '0;
			code_q   <= '0;
			nonhex_q <= 1'b0;
			timer_q  <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			code_q   <= code_d;
			nonhex_q <= nonhex_d;
			timer_q  <= timer_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (accept) begin
			res_vld_q <= 1'b1;
		end else if (result.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			servo_s1 <= servo_d;
			busy_s1  <= busy_d;
			acc_s1   <= acc_d;
			which_s1 <= which_d;
			rej_s1   <= rej_d;
		end
	end

	assign result.valid          = res_vld_q;
	assign result.servo_drive    = servo_s1;
	assign result.door_busy      = busy_s1;
	assign result.tag_accepted   = acc_s1;
	assign result.matched_key    = which_s1;
	assign result.frame_rejected = rej_s1;

	a_accept_starts_unlock: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.tag_accepted |->
			result.servo_drive == SERVO_UNLOCK && result.door_busy && !result.frame_rejected)
		else $error("accepted tag did not start the unlock drive");

	a_idle_servo_off: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.door_busy |-> result.servo_drive == SERVO_OFF)
		else $error("servo driven outside the door sequence");

	a_untimed_timer_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE || phase_q == PH_COLLECT || phase_q == PH_WATCH |-> timer_q == '0)
		else $error("step timer not cleared in an untimed phase");

	a_digit_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(CODE_DIGITS) &&
			(phase_q == PH_IDLE || phase_q == PH_COLLECT || cnt_q == '0))
		else $error("digit count out of range");

	a_busy_tracks_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		accept && opcode_t'(item.opcode) == OP_BYTE && busy_d && !acc_d |=>
			result.door_busy && !result.frame_rejected)
		else $error("byte disturbed a running door sequence");

endmodule

// ===== verif/rfid_tag_whitelist_door_sequencer_top_tb.sv =====
// Testbench for the RFID door sequencer: random frames and ticks checked against a predictor.
module rfid_tag_whitelist_door_sequencer_top_tb;
	import rtds_pkg::*;

	localparam int DIGITS = CODE_DIGITS_DEF;

	typedef struct packed {
		opcode_t    opcode;
		logic [7:0] rx_byte;
		logic       door_pin;
	} door_event_t;

	typedef struct packed {
		servo_t               servo_drive;
		logic                 door_busy;
		logic                 tag_accepted;
		logic [KEY_IDX_W-1:0] matched_key;
		logic                 frame_rejected;
	} door_outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rtds_item_if   item_ch ();
	rtds_result_if res_ch ();
	rtds_cfg_if    cfg_ch ();

	door_event_t         drv_event = '0;
	logic                drv_valid = 1'b0;
	logic                res_ready = 1'b0;
	logic                cfg_valid = 1'b0;
	cfg_reg_t            cfg_index = REG_KEY_ZERO;
	logic [KEY_W-1:0]    cfg_data = '0;

	assign item_ch.valid    = drv_valid;
	assign item_ch.opcode   = drv_event.opcode;
	assign item_ch.rx_byte  = drv_event.rx_byte;
	assign item_ch.door_pin = drv_event.door_pin;
	assign res_ch.ready     = res_ready;
	assign cfg_ch.valid     = cfg_valid;
	assign cfg_ch.index     = cfg_index;
	assign cfg_ch.data      = cfg_data;

	rfid_tag_whitelist_door_sequencer_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always #2 clk = ~clk;

	door_event_t   rx_events[$];
	door_outcome_t door_outcomes[$];
	door_outcome_t want_res;
	int            gap_max = 0;
	int            stall_max = 0;
	int            gap_left = 0;
	int            stall_left = 0;
	int            live_items = 0;
	int            mismatches = 0;

	cfg_t                  door_cfg;
	phase_t                seq_phase = PH_IDLE;
	int                    digit_cnt = 0;
	logic [4*DIGITS-1:0]   code_acc = '0;
	bit                    bad_digit = 1'b0;
	logic [TIME_W-1:0]     step_timer = '0;

	function automatic bit is_hex_digit(logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46);
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] nib);
		return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h37 + 8'(nib);
	endfunction

	function automatic void enter_phase(phase_t p);
		seq_phase = p;
		step_timer = '0;
	endfunction

	function automatic bit step_done(logic [TIME_W-1:0] dur);
		step_timer = step_timer + 1'b1;
		return step_timer >= dur;
	endfunction

	function automatic door_outcome_t predict_door(door_event_t ev);
		door_outcome_t r;
		logic [3:0] nib;
		int hit;
		r = '0;
		hit = -1;
		if (ev.opcode == OP_BYTE) begin
			if (seq_phase == PH_IDLE) begin
				if (ev.rx_byte == BYTE_LF) begin
					live_items++;
					seq_phase = PH_COLLECT;
					digit_cnt = 0;
					code_acc = '0;
					bad_digit = 1'b0;
				end
			end else if (seq_phase == PH_COLLECT) begin
				live_items++;
				if (ev.rx_byte == BYTE_LF || ev.rx_byte == BYTE_CR) begin
					r.frame_rejected = 1'b1;
					enter_phase(PH_IDLE);
				end else begin
					nib = 4'd0;
					if (!is_hex_digit(ev.rx_byte)) begin
						bad_digit = 1'b1;
					end else if (ev.rx_byte <= 8'h39) begin
						nib = ev.rx_byte[3:0];
					end else begin
						nib = ev.rx_byte[3:0] + 4'd9;
					end
					code_acc = (code_acc << 4) | (4*DIGITS)'(nib);
					digit_cnt++;
					if (digit_cnt == DIGITS) begin
						digit_cnt = 0;
						if (!bad_digit) begin
							for (int k = NUM_KEYS - 1; k >= 0; k--) begin
								if (KEY_W'(code_acc) == door_cfg.key[k]) hit = k;
							end
						end
						if (hit >= 0) begin
							r.tag_accepted = 1'b1;
							r.matched_key = KEY_IDX_W'(hit);
							enter_phase(PH_UNLOCK);
						end else begin
							r.frame_rejected = 1'b1;
							enter_phase(PH_IDLE);
						end
					end
				end
			end
		end else begin
			if (seq_phase != PH_IDLE && seq_phase != PH_COLLECT) live_items++;
			case (seq_phase)
			PH_UNLOCK: if (step_done(door_cfg.drive_time)) enter_phase(PH_SETTLE);
			PH_SETTLE: if (step_done(door_cfg.settle_time)) enter_phase(PH_WATCH);
			PH_WATCH: if (!ev.door_pin) enter_phase(PH_DEBOUNCE);
			PH_DEBOUNCE: begin
				if (step_done(door_cfg.debounce_time)) begin
					enter_phase(ev.door_pin ? PH_WATCH : PH_PRELOCK);
				end
			end
			PH_PRELOCK: if (step_done(door_cfg.prelock_time)) enter_phase(PH_LOCK);
			PH_LOCK: if (step_done(door_cfg.drive_time)) enter_phase(PH_IDLE);
			default: ;
			endcase
		end
		case (seq_phase)
		PH_UNLOCK: r.servo_drive = SERVO_UNLOCK;
		PH_LOCK: r.servo_drive = SERVO_LOCK;
		default: r.servo_drive = SERVO_OFF;
		endcase
		r.door_busy = (seq_phase >= PH_UNLOCK);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (drv_valid && item_ch.ready) begin
				door_outcomes.push_back(predict_door(drv_event));
				gap_left = $urandom_range(0, gap_max);
			end
			if (!drv_valid || item_ch.ready) begin
				if (gap_left == 0 && rx_events.size() != 0) begin
					drv_event <= rx_events.pop_front();
					drv_valid <= 1'b1;
				end else begin
					if (gap_left != 0) gap_left--;
					drv_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (res_ch.valid && res_ready) begin
				if (door_outcomes.size() == 0) begin
					$error("result beat with no expected outcome pending");
					mismatches++;
				end else begin
					want_res = door_outcomes.pop_front();
					if (res_ch.servo_drive !== want_res.servo_drive) begin
						$error("servo_drive: expected %0d, got %0d",
							want_res.servo_drive, res_ch.servo_drive);
						mismatches++;
					end
					if (res_ch.door_busy !== want_res.door_busy) begin
						$error("door_busy: expected %0d, got %0d",
							want_res.door_busy, res_ch.door_busy);
						mismatches++;
					end
					if (res_ch.tag_accepted !== want_res.tag_accepted) begin
						$error("tag_accepted: expected %0d, got %0d",
							want_res.tag_accepted, res_ch.tag_accepted);
						mismatches++;
					end
					if (res_ch.matched_key !== want_res.matched_key) begin
						$error("matched_key: expected %0d, got %0d",
							want_res.matched_key, res_ch.matched_key);
						mismatches++;
					end
					if (res_ch.frame_rejected !== want_res.frame_rejected) begin
						$error("frame_rejected: expected %0d, got %0d",
							want_res.frame_rejected, res_ch.frame_rejected);
						mismatches++;
					end
				end
				stall_left = $urandom_range(0, stall_max);
			end
			if (stall_left != 0) begin
				stall_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	function automatic void push_event(opcode_t op, logic [7:0] b, logic pin);
		door_event_t ev;
		ev.opcode = op;
		ev.rx_byte = b;
		ev.door_pin = pin;
		rx_events.push_back(ev);
	endfunction

	// A bad position of -1 gives a clean frame; otherwise that digit is a non-hex byte.
	function automatic void push_frame(logic [KEY_W-1:0] code, int bad_pos);
		logic [7:0] b;
		push_event(OP_BYTE, BYTE_LF, 1'b0);
		for (int i = 0; i < DIGITS; i++) begin
			b = hex_char(code[4*(DIGITS-1-i) +: 4]);
			if (i == bad_pos) begin
				if ($urandom_range(0, 1)) begin
					b = 8'h61 + 8'($urandom_range(0, 5));
				end else begin
					do b = 8'($urandom); while (is_hex_digit(b) || b == BYTE_LF || b == BYTE_CR);
				end
			end
			push_event(OP_BYTE, b, 1'b0);
		end
	endfunction

	function automatic int pick_idle();
		int n;
		n = $urandom_range(0, 9);
		return (n < 3) ? 0 : ((n < 6) ? 3 : 12);
	endfunction

	function automatic cfg_t small_cfg();
		cfg_t c;
		for (int k = 0; k < NUM_KEYS; k++) c.key[k] = KEY_W'({$urandom(), $urandom()});
		c.drive_time = TIME_W'($urandom_range(1, 12));
		c.settle_time = TIME_W'($urandom_range(0, 12));
		c.debounce_time = TIME_W'($urandom_range(1, 12));
		c.prelock_time = TIME_W'($urandom_range(0, 12));
		return c;
	endfunction

	task automatic drain();
		while (rx_events.size() != 0 || drv_valid || door_outcomes.size() != 0) @(posedge clk);
	endtask

	task automatic settle_to_idle();
		gap_max = 0;
		stall_max = 0;
		drain();
		while (seq_phase != PH_IDLE) begin
			if (seq_phase == PH_COLLECT) begin
				push_event(OP_BYTE, BYTE_CR, 1'b0);
			end else begin
				repeat (8) push_event(OP_TICK, 8'h00, 1'b0);
			end
			drain();
		end
	endtask

	task automatic load_config(input cfg_t c);
		logic [KEY_W-1:0] vals [8];
		for (int k = 0; k < NUM_KEYS; k++) vals[k] = c.key[k];
		vals[REG_DRIVE_TIME] = KEY_W'(c.drive_time);
		vals[REG_SETTLE_TIME] = KEY_W'(c.settle_time);
		vals[REG_DEBOUNCE_TIME] = KEY_W'(c.debounce_time);
		vals[REG_PRELOCK_TIME] = KEY_W'(c.prelock_time);
		@(posedge clk);
		for (int k = 0; k < $size(vals); k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= cfg_reg_t'(k);
			cfg_data <= vals[k];
			do @(posedge clk); while (!cfg_ch.ready);
		end
		cfg_valid <= 1'b0;
		door_cfg = c;
	endtask

	task automatic random_traffic(input int quota);
		int kind;
		live_items = 0;
		while (live_items < quota) begin
			kind = $urandom_range(0, 99);
			gap_max = pick_idle();
			stall_max = pick_idle();
			if (kind < 85 && seq_phase == PH_COLLECT) push_event(OP_BYTE, BYTE_CR, 1'b0);
			if (kind < 35) begin
				push_frame(door_cfg.key[$urandom_range(0, NUM_KEYS - 1)], -1);
				repeat ($urandom_range(1, 90)) begin
					push_event(OP_TICK, 8'($urandom), $urandom_range(0, 3) == 0);
				end
			end else if (kind < 45) begin
				repeat ($urandom_range(1, 30)) begin
					push_event(OP_TICK, 8'($urandom), $urandom_range(0, 2) == 0);
				end
			end else if (kind < 55) begin
				push_frame(door_cfg.key[$urandom_range(0, NUM_KEYS - 1)]
					^ (KEY_W'($urandom_range(1, 15)) << (4 * $urandom_range(0, DIGITS - 1))), -1);
			end else if (kind < 65) begin
				push_frame(door_cfg.key[$urandom_range(0, NUM_KEYS - 1)],
					$urandom_range(0, DIGITS - 1));
			end else if (kind < 75) begin
				push_frame(KEY_W'({$urandom(), $urandom()}), -1);
			end else if (kind < 85) begin
				push_event(OP_BYTE, BYTE_LF, 1'b0);
				repeat ($urandom_range(0, DIGITS - 1)) begin
					push_event(OP_BYTE, hex_char(4'($urandom)), 1'b0);
				end
				push_event(OP_BYTE, $urandom_range(0, 1) ? BYTE_LF : BYTE_CR, 1'b0);
			end else begin
				repeat ($urandom_range(1, 6)) begin
					push_event(opcode_t'($urandom_range(0, 1)), 8'($urandom), 1'($urandom));
				end
			end
			drain();
		end
	endtask

	initial begin
		cfg_t next_cfg;
		door_cfg.key[0] = KEY_ZERO_RST;
		door_cfg.key[1] = KEY_ONE_RST;
		door_cfg.key[2] = KEY_TWO_RST;
		door_cfg.key[3] = KEY_THREE_RST;
		door_cfg.drive_time = DRIVE_TIME_RST;
		door_cfg.settle_time = SETTLE_TIME_RST;
		door_cfg.debounce_time = DEBOUNCE_TIME_RST;
		door_cfg.prelock_time = PRELOCK_TIME_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		gap_max = 12;
		stall_max = 12;
		push_event(OP_BYTE, 8'h00, 1'b0);
		push_event(OP_BYTE, 8'hFF, 1'b1);
		push_event(OP_TICK, 8'hFF, 1'b1);
		push_event(OP_TICK, 8'h00, 1'b0);
		push_event(OP_BYTE, BYTE_LF, 1'b0);
		push_event(OP_BYTE, hex_char(4'h1), 1'b0);
		push_event(OP_TICK, 8'h00, 1'b1);
		push_event(OP_BYTE, hex_char(4'hF), 1'b0);
		push_event(OP_BYTE, BYTE_CR, 1'b0);
		push_event(OP_BYTE, BYTE_LF, 1'b0);
		push_event(OP_BYTE, BYTE_LF, 1'b0);
		push_frame(KEY_ZERO_RST, $urandom_range(0, DIGITS - 1));
		drain();

		// Key zero opens the door with the reset timing; shorter steps then end the sequence.
		gap_max = pick_idle();
		stall_max = pick_idle();
		push_frame(door_cfg.key[0], -1);
		repeat (20) push_event(OP_TICK, 8'h00, 1'b0);
		drain();
		next_cfg = door_cfg;
		next_cfg.drive_time = 16'd2;
		next_cfg.settle_time = 16'd3;
		next_cfg.debounce_time = 16'd2;
		next_cfg.prelock_time = 16'd1;
		load_config(next_cfg);
		settle_to_idle();

		// Each remaining reset key opens the door once.
		for (int k = 1; k < NUM_KEYS; k++) begin
			gap_max = pick_idle();
			stall_max = pick_idle();
			push_frame(door_cfg.key[k], -1);
			push_event(OP_BYTE, BYTE_LF, 1'b0);
			settle_to_idle();
		end

		load_config(small_cfg());
		random_traffic(110);
		settle_to_idle();

		next_cfg = small_cfg();
		next_cfg.key[0] = '0;
		next_cfg.key[1] = '1;
		next_cfg.key[2] = '0;
		next_cfg.drive_time = 16'd1;
		next_cfg.settle_time = 16'd0;
		next_cfg.debounce_time = 16'd1;
		next_cfg.prelock_time = 16'd0;
		load_config(next_cfg);
		random_traffic(110);
		settle_to_idle();

		next_cfg = small_cfg();
		next_cfg.key[3] = next_cfg.key[1];
		next_cfg.drive_time = 16'd0;
		next_cfg.debounce_time = 16'd0;
		load_config(next_cfg);
		random_traffic(110);
		settle_to_idle();

		next_cfg = small_cfg();
		next_cfg.drive_time = 16'd16;
		next_cfg.settle_time = 16'd16;
		next_cfg.debounce_time = 16'd16;
		next_cfg.prelock_time = 16'd16;
		load_config(next_cfg);
		push_frame(next_cfg.key[3], -1);
		settle_to_idle();

		repeat (16) @(posedge clk);
		if (mismatches == 0) begin
			$display("rfid_tag_whitelist_door_sequencer_top: match");
		end else begin
			$display("rfid_tag_whitelist_door_sequencer_top: mismatch");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("rfid_tag_whitelist_door_sequencer_top: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/rtds_pkg.sv
hw/rtl/rtds_item_if.sv
hw/rtl/rtds_result_if.sv
hw/rtl/rtds_cfg_if.sv
hw/rtl/rtds_regs.sv
hw/rtl/rfid_tag_whitelist_door_sequencer_top.sv
verif/rfid_tag_whitelist_door_sequencer_top_tb.sv
